[rtl/i2ctvs_pkg.sv]
// i2ctvs_pkg: shared types, line codes and count helpers for the I2C vector
// sequencer. No dependencies; used by the top level and its checker.
package i2ctvs_pkg;

    localparam int MAX_DATA_BYTES = 255;
    localparam int MAX_REG_BYTES  = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int OFFSET_W    = 12;

    // config register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_ADDR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REG_ADDR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REG_BYTES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_BYTES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_MODE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_HIZ   = 3'd5;

    // pin codes of one vector line
    localparam logic [1:0] CODE_DRIVE0 = 2'd0;
    localparam logic [1:0] CODE_DRIVE1 = 2'd1;
    localparam logic [1:0] CODE_EXPECT_L = 2'd2;
    localparam logic [1:0] CODE_HIGH_Z = 2'd3;

    // input item modes
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_DATA  = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] write_data;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]          scl_code;
        logic [1:0]          sda_code;
        logic [OFFSET_W-1:0] line_offset;
        logic                ack_check;
        logic                transaction_done;
        logic                last;
    } out_beat_t;

    // register byte count saturated into 1..MAX_REG_BYTES
    function automatic logic [2:0] reg_count(input logic [2:0] cnt);
        logic [2:0] res;
        begin
            res = cnt;
            if (cnt == 3'd0)
            begin
                res = 3'd1;
            end
            else if (32'(cnt) > MAX_REG_BYTES)
            begin
                res = 3'(MAX_REG_BYTES);
            end
            return res;
        end
    endfunction

    // data byte count saturated to MAX_DATA_BYTES
    function automatic logic [7:0] data_count(input logic [7:0] cnt);
        logic [7:0] res;
        begin
            res = cnt;
            if (32'(cnt) > MAX_DATA_BYTES)
            begin
                res = 8'(MAX_DATA_BYTES);
            end
            return res;
        end
    endfunction

endpackage

[rtl/i2c_transaction_vector_sequencer.sv]
// i2c_transaction_vector_sequencer: top level, emits tester vector lines for
// one I2C master transaction. Depends on i2ctvs_pkg.
//
// Usage:
//   cfg channel  - cfg_valid/cfg_ready with cfg_index and cfg_data; always
//                  ready. Index 0 slave address, 1 register address, 2 register
//                  byte count, 3 data byte count, 4 read mode, 5 stop high-Z.
//                  Write only while the block is idle.
//   in channel   - one beat is a begin item or one data byte item.
//   out channel  - one beat per vector line; last marks the final line of an
//                  item, transaction_done the final stop line.
// Timing: a single sequencer walks the line segments (start, byte, repeated
//   start, stop) and a shared 8-bit shift register plus bit counter serve all
//   byte segments, one line per cycle unless the output stalls. An item is
//   accepted while idle; with a ready receiver its lines follow back to back.
//   A data item makes 9 lines (13 with stop); a begin item makes
//   12 + 9*register_bytes lines (+12 in read mode, +4 if no data bytes), up to
//   64 lines. Accept moves the sequencer to its start segment, whose first line
//   then enters the output register. in_ready is low while lines are produced.
// Items out of place (data while idle, begin mid-transaction) are dropped
//   with no lines.
// Reset: idle, no transaction open, line offset zero, config at reset values.
// Stall: a line waits in the output register; the sequencer freezes until the
//   receiver takes it, so no line is lost or repeated.
module i2c_transaction_vector_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2ctvs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [i2ctvs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  i2ctvs_pkg::in_beat_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output i2ctvs_pkg::out_beat_t               out_data
);

    // sequencer segments
    localparam logic [2:0] SEG_IDLE   = 3'd0;
    localparam logic [2:0] SEG_START  = 3'd1;
    localparam logic [2:0] SEG_SLA_W  = 3'd2;
    localparam logic [2:0] SEG_REG    = 3'd3;
    localparam logic [2:0] SEG_RSTART = 3'd4;
    localparam logic [2:0] SEG_SLA_R  = 3'd5;
    localparam logic [2:0] SEG_DATA   = 3'd6;
    localparam logic [2:0] SEG_STOP   = 3'd7;

    localparam logic [3:0] STEP_COND_END = 4'd2;  // start / repeated start
    localparam logic [3:0] STEP_STOP_END = 4'd3;
    localparam logic [3:0] STEP_BYTE_END = 4'd8;  // 8 bits + ack slot

    // config registers
    logic [7:0]  slave_addr_reg;
    logic [31:0] reg_addr_reg;
    logic [2:0]  reg_bytes_reg;
    logic [7:0]  data_bytes_reg;
    logic        read_mode_reg;
    logic        stop_hiz_reg;

    // transaction state
    logic                         phase_reg, phase_next;   // 1 = data phase open
    logic [7:0]                   bytes_done_reg, bytes_done_next;
    logic [i2ctvs_pkg::OFFSET_W-1:0] line_cnt_reg, line_cnt_next;

    // sequencer
    logic [2:0] seg_reg, seg_next;
    logic [3:0] step_reg, step_next;
    logic [1:0] reg_left_reg, reg_left_next;
    logic       last_byte_reg, last_byte_next;
    logic [7:0] shift_reg, shift_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    i2ctvs_pkg::out_beat_t out_data_reg, line, line_out;

    logic       in_fire, can_emit, emit, seg_end, rd_data, last_byte;
    logic [7:0] cnt, sla;
    logic [2:0] rc;
    logic [1:0] reg_idx, stop_code;
    logic [7:0] reg_byte;

    assign cfg_ready = 1'b1;
    assign in_ready  = (seg_reg == SEG_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign can_emit  = !out_valid_reg || out_ready;
    assign emit      = (seg_reg != SEG_IDLE) && can_emit;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cnt       = i2ctvs_pkg::data_count(data_bytes_reg);
    assign rc        = i2ctvs_pkg::reg_count(reg_bytes_reg);
    assign sla       = {slave_addr_reg[7:1], 1'b0};
    assign rd_data   = (seg_reg == SEG_DATA) && read_mode_reg;
    assign last_byte = ({1'b0, bytes_done_reg} + 9'd1) >= {1'b0, cnt};
    assign stop_code = stop_hiz_reg ? i2ctvs_pkg::CODE_HIGH_Z : i2ctvs_pkg::CODE_DRIVE1;

    // register byte select, MSB first
    always_comb
    begin
        reg_idx = (seg_reg == SEG_SLA_W) ? 2'(rc - 3'd1) : 2'(reg_left_reg - 2'd1);
        unique case (reg_idx)
            2'd0:    reg_byte = reg_addr_reg[7:0];
            2'd1:    reg_byte = reg_addr_reg[15:8];
            2'd2:    reg_byte = reg_addr_reg[23:16];
            default: reg_byte = reg_addr_reg[31:24];
        endcase
    end

    // line pattern of the current segment and step
    always_comb
    begin
        line             = '0;
        line.line_offset = line_cnt_reg;
        seg_end          = 1'b0;
        unique case (seg_reg)
            SEG_START, SEG_RSTART:
            begin
                seg_end = (step_reg == STEP_COND_END);
                line.scl_code = ((seg_reg == SEG_RSTART) && (step_reg == 4'd0))
                              ? i2ctvs_pkg::CODE_DRIVE0 : i2ctvs_pkg::CODE_DRIVE1;
                line.sda_code = (step_reg == STEP_COND_END)
                              ? i2ctvs_pkg::CODE_DRIVE0 : i2ctvs_pkg::CODE_DRIVE1;
            end
            SEG_STOP:
            begin
                seg_end = (step_reg == STEP_STOP_END);
                unique case (step_reg)
                    4'd0:
                    begin
                        line.scl_code = i2ctvs_pkg::CODE_DRIVE0;
                        line.sda_code = i2ctvs_pkg::CODE_DRIVE0;
                    end
                    4'd1:
                    begin
                        line.scl_code = i2ctvs_pkg::CODE_DRIVE1;
                        line.sda_code = i2ctvs_pkg::CODE_DRIVE0;
                    end
                    4'd2:
                    begin
                        line.scl_code = i2ctvs_pkg::CODE_DRIVE1;
                        line.sda_code = i2ctvs_pkg::CODE_DRIVE1;
                    end
                    default:
                    begin
                        line.scl_code         = stop_code;
                        line.sda_code         = stop_code;
                        line.transaction_done = 1'b1;
                    end
                endcase
            end
            SEG_SLA_W, SEG_REG, SEG_SLA_R, SEG_DATA:
            begin
                seg_end       = (step_reg == STEP_BYTE_END);
                line.scl_code = i2ctvs_pkg::CODE_DRIVE0;
                if (step_reg == STEP_BYTE_END)
                begin
                    if (rd_data)
                    begin
                        // master ACK, NACK on the final byte
                        line.sda_code = last_byte_reg ? i2ctvs_pkg::CODE_DRIVE1
                                                      : i2ctvs_pkg::CODE_DRIVE0;
                    end
                    else
                    begin
                        line.sda_code  = i2ctvs_pkg::CODE_EXPECT_L;
                        line.ack_check = 1'b1;
                    end
                end
                else if (rd_data)
                begin
                    line.sda_code = i2ctvs_pkg::CODE_EXPECT_L;
                end
                else
                begin
                    line.sda_code = shift_reg[7] ? i2ctvs_pkg::CODE_DRIVE1
                                                 : i2ctvs_pkg::CODE_DRIVE0;
                end
            end
            default:
            begin
                seg_end = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_done_next = bytes_done_reg;
        line_cnt_next   = line_cnt_reg;
        seg_next        = seg_reg;
        step_next       = step_reg;
        reg_left_next   = reg_left_reg;
        last_byte_next  = last_byte_reg;
        shift_next      = shift_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (in_fire)
        begin
            if ((in_data.mode == i2ctvs_pkg::MODE_BEGIN) && !phase_reg)
            begin
                seg_next        = SEG_START;
                step_next       = 4'd0;
                line_cnt_next   = '0;
                bytes_done_next = 8'd0;
                phase_next      = (cnt != 8'd0);
            end
            else if ((in_data.mode == i2ctvs_pkg::MODE_DATA) && phase_reg)
            begin
                seg_next        = SEG_DATA;
                step_next       = 4'd0;
                shift_next      = in_data.write_data;
                last_byte_next  = last_byte;
                bytes_done_next = bytes_done_reg + 8'd1;
                phase_next      = !last_byte;
            end
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            line_cnt_next  = line_cnt_reg + {{(i2ctvs_pkg::OFFSET_W-1){1'b0}}, 1'b1};
            step_next      = step_reg + 4'd1;
            shift_next     = {shift_reg[6:0], 1'b0};
            if (seg_end)
            begin
                step_next = 4'd0;
                unique case (seg_reg)
                    SEG_START:
                    begin
                        seg_next   = SEG_SLA_W;
                        shift_next = sla;
                    end
                    SEG_SLA_W:
                    begin
                        seg_next      = SEG_REG;
                        shift_next    = reg_byte;
                        reg_left_next = 2'(rc - 3'd1);
                    end
                    SEG_REG:
                    begin
                        if (reg_left_reg != 2'd0)
                        begin
                            shift_next    = reg_byte;
                            reg_left_next = reg_left_reg - 2'd1;
                        end
                        else if (read_mode_reg)
                        begin
                            seg_next = SEG_RSTART;
                        end
                        else
                        begin
                            seg_next = (cnt == 8'd0) ? SEG_STOP : SEG_IDLE;
                        end
                    end
                    SEG_RSTART:
                    begin
                        seg_next   = SEG_SLA_R;
                        shift_next = sla | 8'h01;
                    end
                    SEG_SLA_R:
                    begin
                        seg_next = (cnt == 8'd0) ? SEG_STOP : SEG_IDLE;
                    end
                    SEG_DATA:
                    begin
                        seg_next = last_byte_reg ? SEG_STOP : SEG_IDLE;
                    end
                    SEG_STOP:
                    begin
                        seg_next = SEG_IDLE;
                    end
                    default:
                    begin
                        seg_next = SEG_IDLE;
                    end
                endcase
            end
        end
    end

    // line as registered, last set when the item ends with it
    always_comb
    begin
        line_out      = line;
        line_out.last = seg_end && (seg_next == SEG_IDLE);
    end

    // control and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr_reg <= 8'd0;
            reg_addr_reg   <= 32'd0;
            reg_bytes_reg  <= 3'd1;
            data_bytes_reg <= 8'd0;
            read_mode_reg  <= 1'b0;
            stop_hiz_reg   <= 1'b0;
            phase_reg      <= 1'b0;
            bytes_done_reg <= 8'd0;
            line_cnt_reg   <= '0;
            seg_reg        <= SEG_IDLE;
            step_reg       <= 4'd0;
            reg_left_reg   <= 2'd0;
            last_byte_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    i2ctvs_pkg::CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[7:0];
                    i2ctvs_pkg::CFG_REG_ADDR:   reg_addr_reg   <= cfg_data[31:0];
                    i2ctvs_pkg::CFG_REG_BYTES:  reg_bytes_reg  <= cfg_data[2:0];
                    i2ctvs_pkg::CFG_DATA_BYTES: data_bytes_reg <= cfg_data[7:0];
                    i2ctvs_pkg::CFG_READ_MODE:  read_mode_reg  <= cfg_data[0];
                    i2ctvs_pkg::CFG_STOP_HIZ:   stop_hiz_reg   <= cfg_data[0];
                    default:        ;
                endcase
            end
            phase_reg      <= phase_next;
            bytes_done_reg <= bytes_done_next;
            line_cnt_reg   <= line_cnt_next;
            seg_reg        <= seg_next;
            step_reg       <= step_next;
            reg_left_reg   <= reg_left_next;
            last_byte_reg  <= last_byte_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (emit)
        begin
            out_data_reg <= line_out;
        end
    end

endmodule

[rtl/i2ctvs_checker.sv]
// i2ctvs_checker: port-level assertions for the I2C vector sequencer, bound
// to the top level by the bind below. Depends on i2ctvs_pkg.
module i2ctvs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input i2ctvs_pkg::out_beat_t               out_data
);

    // a stalled line beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed under stall");

    // the final stop line always closes the item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.transaction_done |-> out_data.last)
        else $error("transaction_done without last");

    // an ACK check is an expect-low line with SCL low
    a_ack_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ack_check |->
            (out_data.sda_code == i2ctvs_pkg::CODE_EXPECT_L) &&
            (out_data.scl_code == i2ctvs_pkg::CODE_DRIVE0))
        else $error("ack_check on a line that is not expect-low");

    // no new item while an item's lines are still coming
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> !in_ready)
        else $error("input ready in the middle of an item");

endmodule

bind i2c_transaction_vector_sequencer i2ctvs_checker u_i2ctvs_checker (.*);

[tb/i2c_transaction_vector_sequencer_tb.sv]
// i2c_transaction_vector_sequencer_tb: self-checking bench for the I2C vector
// sequencer, with a line predictor in a scoreboard class and task-driven stimulus.
// Depends on i2ctvs_pkg and the i2c_transaction_vector_sequencer top level.
module i2c_transaction_vector_sequencer_tb;

    import i2ctvs_pkg::*;

    // configuration register indexes, in register-map order
    localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS       = CFG_SLAVE_ADDR;
    localparam logic [CFG_INDEX_W-1:0] REG_REGISTER_ADDRESS    = CFG_REG_ADDR;
    localparam logic [CFG_INDEX_W-1:0] REG_REGISTER_BYTE_COUNT = CFG_REG_BYTES;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_BYTE_COUNT     = CFG_DATA_BYTES;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_MODE           = CFG_READ_MODE;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_HIGH_Z         = CFG_STOP_HIZ;

    localparam int RANDOM_ITEMS = 220;
    localparam int DRAIN_CYCLES = 16;    // covers output register plus drop of a stray item
    localparam int HOLD_CYCLES  = 250;   // long receiver stall, fills the block
    localparam int STALL_LIMIT  = 4000;  // cycles with no beat on any channel
    localparam int REPORT_LIMIT = 10;

    // Scoreboard: keeps its own copy of the registers and the transaction
    // state, expands every accepted input beat into the vector lines it must
    // produce, and checks output beats against them in order.
    class line_scoreboard;
        logic [7:0]          slave_addr;
        logic [31:0]         reg_addr;
        logic [2:0]          reg_bytes;
        logic [7:0]          data_bytes;
        logic                read_txn;
        logic                stop_hz;
        bit                  txn_open;
        logic [7:0]          bytes_sent;
        logic [OFFSET_W-1:0] line_no;
        out_beat_t           expected_lines[$];
        int                  mismatches;

        function new();
            slave_addr = 8'h00;
            reg_addr   = 32'h0;
            reg_bytes  = 3'd1;
            data_bytes = 8'd0;
            read_txn   = 1'b0;
            stop_hz    = 1'b0;
            txn_open   = 1'b0;
            bytes_sent = 8'd0;
            line_no    = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_SLAVE_ADDRESS:       slave_addr = value[7:0];
                REG_REGISTER_ADDRESS:    reg_addr   = value;
                REG_REGISTER_BYTE_COUNT: reg_bytes  = value[2:0];
                REG_DATA_BYTE_COUNT:     data_bytes = value[7:0];
                REG_READ_MODE:           read_txn   = value[0];
                REG_STOP_HIGH_Z:         stop_hz    = value[0];
                default: ;
            endcase
        endfunction

        function void push_line(logic [1:0] scl, logic [1:0] sda, logic ack, logic done);
            out_beat_t line;
            line.scl_code         = scl;
            line.sda_code         = sda;
            line.line_offset      = line_no;
            line.ack_check        = ack;
            line.transaction_done = done;
            line.last             = 1'b0;
            expected_lines.insert(expected_lines.size(), line);
            line_no = line_no + OFFSET_W'(1);   // wraps at 12 bits
        endfunction

        // eight bit lines MSB first, then the ninth (ack) line
        function void push_byte(logic [7:0] value, logic [1:0] tail, logic ack);
            for (int i = 7; i >= 0; i--)
                push_line(CODE_DRIVE0, value[i] ? CODE_DRIVE1 : CODE_DRIVE0, 1'b0, 1'b0);
            push_line(CODE_DRIVE0, tail, ack, 1'b0);
        endfunction

        // read byte: expect low on every bit, then master ACK or NACK
        function void push_read_byte(logic [1:0] tail);
            for (int i = 0; i < 8; i++)
                push_line(CODE_DRIVE0, CODE_EXPECT_L, 1'b0, 1'b0);
            push_line(CODE_DRIVE0, tail, 1'b0, 1'b0);
        endfunction

        function void push_stop();
            logic [1:0] fin;
            fin = stop_hz ? CODE_HIGH_Z : CODE_DRIVE1;
            push_line(CODE_DRIVE0, CODE_DRIVE0, 1'b0, 1'b0);
            push_line(CODE_DRIVE1, CODE_DRIVE0, 1'b0, 1'b0);
            push_line(CODE_DRIVE1, CODE_DRIVE1, 1'b0, 1'b0);
            push_line(fin, fin, 1'b0, 1'b1);
        endfunction

        // Expand one accepted input beat; returns the number of lines it causes
        // (zero for an out-of-place item, which the block drops).
        function int note_item(in_beat_t item);
            int first;
            int addr_bytes;
            int byte_limit;
            bit final_byte;
            first = expected_lines.size();
            // registers are live: counts are taken at the moment of the item
            byte_limit = (int'(data_bytes) > MAX_DATA_BYTES) ? MAX_DATA_BYTES
                                                             : int'(data_bytes);
            if (item.mode == MODE_BEGIN)
            begin
                if (txn_open)
                    return 0;
                line_no    = '0;
                bytes_sent = 8'd0;
                push_line(CODE_DRIVE1, CODE_DRIVE1, 1'b0, 1'b0);
                push_line(CODE_DRIVE1, CODE_DRIVE1, 1'b0, 1'b0);
                push_line(CODE_DRIVE1, CODE_DRIVE0, 1'b0, 1'b0);
                push_byte({slave_addr[7:1], 1'b0}, CODE_EXPECT_L, 1'b1);
                addr_bytes = int'(reg_bytes);
                if (addr_bytes < 1)
                    addr_bytes = 1;
                if (addr_bytes > MAX_REG_BYTES)
                    addr_bytes = MAX_REG_BYTES;
                for (int i = addr_bytes - 1; i >= 0; i--)
                    push_byte(reg_addr[8*i +: 8], CODE_EXPECT_L, 1'b1);
                if (read_txn)
                begin
                    // repeated start, then slave byte with R/W set
                    push_line(CODE_DRIVE0, CODE_DRIVE1, 1'b0, 1'b0);
                    push_line(CODE_DRIVE1, CODE_DRIVE1, 1'b0, 1'b0);
                    push_line(CODE_DRIVE1, CODE_DRIVE0, 1'b0, 1'b0);
                    push_byte({slave_addr[7:1], 1'b1}, CODE_EXPECT_L, 1'b1);
                end
                if (byte_limit == 0)
                    push_stop();
                else
                    txn_open = 1'b1;
            end
            else
            begin
                if (!txn_open)
                    return 0;
                // a count lowered mid-transaction makes this byte the last one
                final_byte = (int'(bytes_sent) + 1) >= byte_limit;
                if (read_txn)
                    push_read_byte(final_byte ? CODE_DRIVE1 : CODE_DRIVE0);
                else
                    push_byte(item.write_data, CODE_EXPECT_L, 1'b1);
                bytes_sent = bytes_sent + 8'd1;
                if (final_byte)
                begin
                    push_stop();
                    txn_open = 1'b0;
                end
            end
            expected_lines[expected_lines.size() - 1].last = 1'b1;
            return expected_lines.size() - first;
        endfunction

        function void check_line(out_beat_t got);
            out_beat_t want;
            if (expected_lines.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] unexpected line: %p", $time, got);
                return;
            end
            want = expected_lines.pop_front();
            if (got.scl_code !== want.scl_code || got.sda_code !== want.sda_code ||
                got.line_offset !== want.line_offset || got.ack_check !== want.ack_check ||
                got.transaction_done !== want.transaction_done || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] line mismatch: expected %p, actual %p", $time, want, got);
            end
        endfunction

        function int pending();
            return expected_lines.size();
        endfunction

        function bit in_transaction();
            return txn_open;
        endfunction
    endclass

    logic      clk;
    logic      rst_n = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    line_scoreboard sb;
    int unsigned    send_idle_pct = 36;
    int unsigned    recv_idle_pct = 54;
    bit             hold_request = 1'b0;
    int             items_taken = 0;   // accepted items that produced lines
    int             quiet_cycles = 0;

    i2c_transaction_vector_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random backpressure at recv_idle_pct. On request it holds
    // ready low for a long stretch so the block backs up into its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output checker and watchdog. The watchdog restarts on any beat on
    // any channel, so long legal stalls are fine but a hang is not.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_line(out_data);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("i2c_transaction_vector_sequencer_tb: errors");
            $finish;
        end
    end

    function automatic in_beat_t make_item(logic mode, logic [7:0] value);
        in_beat_t item;
        item.mode       = mode;
        item.write_data = value;
        return item;
    endfunction

    // One input beat. Valid is left high after the accepting edge; it only
    // drops at the start of a gap or in drain(), so it never toggles twice
    // in one time step.
    task automatic send_item(input in_beat_t item);
        int lines;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        lines = sb.note_item(item);
        if (lines > 0)
            items_taken++;
    endtask

    task automatic send_data(input logic [7:0] value);
        send_item(make_item(MODE_DATA, value));
    endtask

    task automatic send_begin();
        send_item(make_item(MODE_BEGIN, 8'($urandom)));
    endtask

    // Wait until every predicted line has come out, then let the block
    // settle before the registers may be touched.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [7:0] slave, input logic [31:0] reg_address,
                             input logic [2:0] reg_count, input logic [7:0] data_count,
                             input logic read_txn, input logic stop_hz);
        write_reg(REG_SLAVE_ADDRESS, {24'd0, slave});
        write_reg(REG_REGISTER_ADDRESS, reg_address);
        write_reg(REG_REGISTER_BYTE_COUNT, {29'd0, reg_count});
        write_reg(REG_DATA_BYTE_COUNT, {24'd0, data_count});
        write_reg(REG_READ_MODE, {31'd0, read_txn});
        write_reg(REG_STOP_HIGH_Z, {31'd0, stop_hz});
    endtask

    initial
    begin
        int directed_items;
        int done_random;
        int sent;
        int pick;
        bit hold_done;
        logic [7:0] byte_count;

        sb = new();
        hold_done = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // reset values: write, one register byte, no data bytes
        send_data(8'hA5);                   // data while idle: dropped
        send_begin();                       // start, slave, reg, stop
        drain();

        // all-ones registers, four register bytes, stop line high-Z
        configure(8'hFF, 32'hFFFF_FFFF, 3'd4, 8'd2, 1'b0, 1'b1);
        send_begin();
        send_begin();                       // begin mid-transaction: dropped
        send_data(8'hFF);
        send_data(8'h00);
        drain();

        // address masked to three bytes, alternating data patterns
        configure(8'h5A, 32'hA5C3_7E18, 3'd3, 8'd3, 1'b0, 1'b0);
        send_begin();
        send_data(8'h55);
        send_data(8'hAA);
        send_data(8'h81);
        drain();

        // read, single byte -> NACK; register count above range saturates
        configure(8'hA7, 32'h0000_1234, 3'd7, 8'd1, 1'b1, 1'b1);
        send_begin();
        send_data(8'h3C);
        drain();

        // read with no data bytes: stop right after the repeated-start byte;
        // zero register count saturates to one
        configure(8'h00, 32'h0000_0000, 3'd0, 8'd0, 1'b1, 1'b0);
        send_begin();
        drain();
        // longest begin item: four register bytes, read, no data
        write_reg(REG_REGISTER_BYTE_COUNT, 32'd4);
        write_reg(REG_SLAVE_ADDRESS, 32'hFE);
        send_begin();
        drain();

        // largest byte count, then lowered mid-transaction
        configure(8'h3C, 32'h89AB_CDEF, 3'd5, 8'd255, 1'b1, 1'b1);
        send_begin();
        send_data(8'h00);
        send_data(8'hFF);
        drain();
        write_reg(REG_DATA_BYTE_COUNT, 32'd1);
        send_data(8'h12);                   // becomes the last byte
        drain();

        // read mode switched on mid-transaction, then count dropped to zero
        configure(8'hC3, 32'h7654_3210, 3'd6, 8'd255, 1'b0, 1'b0);
        send_begin();
        send_data(8'h96);
        send_data(8'h69);
        drain();
        write_reg(REG_READ_MODE, 32'd1);
        send_data(8'h00);
        drain();
        write_reg(REG_DATA_BYTE_COUNT, 32'd0);
        send_data(8'h00);
        drain();

        directed_items = items_taken;

        // ---- random transactions ----
        while (items_taken - directed_items < RANDOM_ITEMS)
        begin
            done_random = items_taken - directed_items;
            if (done_random < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 54;
            end
            else if (done_random < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            pick = $urandom_range(99);
            if (pick < 70)
                byte_count = 8'($urandom_range(0, 6));
            else if (pick < 95)
                byte_count = 8'($urandom_range(7, 20));
            else
                byte_count = 8'd255;
            // one long receiver stall once the bench runs with no idling
            if (send_idle_pct == 0 && !hold_done)
                byte_count = 8'd16;
            configure(8'($urandom), 32'($urandom), 3'($urandom_range(0, 7)), byte_count,
                      1'($urandom), 1'($urandom));

            if ($urandom_range(99) < 10)
                send_data(8'($urandom));    // stray byte while idle
            if (send_idle_pct == 0 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_request = 1'b1;
            end
            send_begin();
            sent = 0;
            while (sb.in_transaction())
            begin
                if ($urandom_range(99) < 8)
                    send_begin();           // stray begin mid-transaction
                if (sent >= 20 || $urandom_range(99) < 5)
                begin
                    // reshape the open transaction between bytes
                    drain();
                    if ($urandom_range(1) == 0 || sent >= 20)
                        write_reg(REG_DATA_BYTE_COUNT, 32'($urandom_range(0, sent + 3)));
                    else
                        write_reg(REG_READ_MODE, 32'($urandom_range(1)));
                end
                send_data(8'($urandom));
                sent++;
            end
            drain();
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("i2c_transaction_vector_sequencer_tb: clean");
        else
            $display("i2c_transaction_vector_sequencer_tb: errors");
        $finish;
    end

endmodule
